### rtl/lightmap_brightness_normalize_top_assert.svh
// ----------------------------------------------------------------------------
// lightmap brightness normalize assertion macros
// concurrent assertion forms for lightmap_brightness_normalize_top
// ----------------------------------------------------------------------------
`ifndef LIGHTMAP_BRIGHTNESS_NORMALIZE_TOP_ASSERT_SVH
`define LIGHTMAP_BRIGHTNESS_NORMALIZE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle, quiet during reset
`define LBN_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbn implication check failed");

// consequence must hold in the cycle after reset is seen
`define LBN_ASSERT_AFTER_RESET(name, clk, rst, cons) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("lbn post-reset check failed");

`endif

### rtl/lbn_pkg.sv
// ----------------------------------------------------------------------------
// lbn_pkg
// widths, constants, pipeline payload type and divider step function
// ----------------------------------------------------------------------------
package lbn_pkg;

   localparam int CHAN_W     = 8;
   localparam int GAIN_W     = 12;
   localparam int FRAC_W     = 8;
   localparam int PROD_W     = CHAN_W + GAIN_W;
   localparam int REM_W      = 2 * CHAN_W;
   localparam int LANES      = 3;
   localparam int STEP_BITS  = 2;
   localparam int DIV_STAGES = CHAN_W / STEP_BITS;
   localparam int NUM_STAGES = DIV_STAGES + 2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd640;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [LANES-1:0][CHAN_W-1:0] pix_type;

   typedef struct packed {
      logic                         over;
      chan_type                     top;
      logic [LANES-1:0][REM_W-1:0]  rem;
      pix_type                      quot;
      pix_type                      scaled;
   } div_type;

   // one restoring step on every lane: quotient bit pos of rem / top
   function automatic div_type div_step(div_type x, logic [2:0] pos);
      div_type           y;
      logic [REM_W-1:0]  dvs;
      y   = x;
      dvs = REM_W'(x.top) << pos;
      for (int l = 0; l < LANES; l++) begin
         if (x.rem[l] >= dvs) begin
            y.rem[l]       = x.rem[l] - dvs;
            y.quot[l][pos] = 1'b1;
         end
      end
      return y;
   endfunction

endpackage

### rtl/lbn_if.sv
// ----------------------------------------------------------------------------
// lbn channel interfaces
// valid/ready channels for incoming pixels and normalized pixels
// ----------------------------------------------------------------------------
interface lbn_req_if import lbn_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red_in;
   chan_type green_in;
   chan_type blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface lbn_rsp_if import lbn_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red_out;
   chan_type green_out;
   chan_type blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/lbn_front.sv
// ----------------------------------------------------------------------------
// lbn_front
// gain multiply, overflow detect, max channel and divider numerator
// ----------------------------------------------------------------------------
module lbn_front import lbn_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  pix_type           pix,
   input  logic [GAIN_W-1:0] gain,
   output div_type           q
);

   div_type                   front_ff;
   div_type                   front_in;
   logic [LANES-1:0][PROD_W-1:0] prod;

   always_comb begin
      front_in = '0;
      for (int l = 0; l < LANES; l++) begin
         prod[l] = PROD_W'(pix[l]) * PROD_W'(gain);
         front_in.scaled[l] = prod[l][FRAC_W+CHAN_W-1:FRAC_W];
         // scaled value needs more than eight bits
         if (|prod[l][PROD_W-1:FRAC_W+CHAN_W]) begin
            front_in.over = 1'b1;
         end
         // channel * 255
         front_in.rem[l] = (REM_W'(pix[l]) << CHAN_W) - REM_W'(pix[l]);
      end
      front_in.top = pix[0];
      for (int l = 1; l < LANES; l++) begin
         if (pix[l] > front_in.top) begin
            front_in.top = pix[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

   assign q = front_ff;

endmodule

### rtl/lbn_divider.sv
// ----------------------------------------------------------------------------
// lbn_divider
// pipelined restoring divider, two quotient bits per stage on all lanes
// ----------------------------------------------------------------------------
module lbn_divider import lbn_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] load,
   input  div_type               d_in,
   output div_type               d_out
);

   div_type stage_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int HI = CHAN_W - 1 - STEP_BITS * s;
      div_type stage_in;

      always_comb begin
         stage_in = (s == 0) ? d_in : stage_ff[(s == 0) ? 0 : s - 1];
         for (int j = 0; j < STEP_BITS; j++) begin
            stage_in = div_step(stage_in, 3'(HI - j));
         end
      end

      always_ff @(posedge clock) begin
         if (load[s]) begin
            stage_ff[s] <= stage_in;
         end
      end
   end

   assign d_out = stage_ff[DIV_STAGES-1];

endmodule

### rtl/lightmap_brightness_normalize_top.sv
// ----------------------------------------------------------------------------
// lightmap_brightness_normalize_top
// lightmap pixel brightening with hue-preserving overbright normalization
// ----------------------------------------------------------------------------
// Takes one RGB pixel per cycle and returns one pixel per cycle when the
// output is not stalled. Each channel is multiplied by the Q4.8 gain in
// csr_wr_data (reset 2.5); if any scaled channel would pass 255, the pixel
// is instead rescaled so that its largest channel reads 255. The pipeline
// holds the multiply stage, four divider stages that each settle two
// quotient bits on all three channels, and the output register. Backpressure
// on rsp holds every full stage without dropping an item, while empty stages
// still take new data; no clearing pass is needed after reset.
`include "lightmap_brightness_normalize_top_assert.svh"

module lightmap_brightness_normalize_top import lbn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lbn_req_if.sink           req,
   lbn_rsp_if.source         rsp,
   input  logic              csr_wr_en,
   input  logic [GAIN_W-1:0] csr_wr_data
);

   logic [GAIN_W-1:0]     gain_ff;
   logic [GAIN_W-1:0]     gain_in;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   load;
   pix_type               pix;
   div_type               front_q;
   div_type               div_out;
   pix_type               out_ff;
   pix_type               out_in;
   logic                  out_over_ff;

   assign gain_in = csr_wr_en ? csr_wr_data : gain_ff;

   // a stage may take new data when empty or when its content moves on
   always_comb begin
      load[NUM_STAGES] = rsp.ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         valid_ff <= '0;
      end else begin
         gain_ff <= gain_in;
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign pix = {req.blue_in, req.green_in, req.red_in};

   lbn_front u_front (
      .clock (clock),
      .load  (load[0]),
      .pix   (pix),
      .gain  (gain_ff),
      .q     (front_q)
   );

   lbn_divider u_divider (
      .clock (clock),
      .load  (load[DIV_STAGES:1]),
      .d_in  (front_q),
      .d_out (div_out)
   );

   assign out_in = div_out.over ? div_out.quot : div_out.scaled;

   always_ff @(posedge clock) begin
      if (load[NUM_STAGES-1]) begin
         out_ff      <= out_in;
         out_over_ff <= div_out.over;
      end
   end

   assign req.ready     = load[0];
   assign rsp.valid     = valid_ff[NUM_STAGES-1];
   assign rsp.red_out   = out_ff[0];
   assign rsp.green_out = out_ff[1];
   assign rsp.blue_out  = out_ff[2];

   `LBN_ASSERT_AFTER_RESET(a_reset_empties, clock, reset, valid_ff == '0)
   `LBN_ASSERT_IMPLY(a_over_nonzero_top, clock, reset, valid_ff[0] && front_q.over,
      front_q.top != '0)
   `LBN_ASSERT_IMPLY(a_div_rem_below_top, clock, reset,
      valid_ff[NUM_STAGES-2] && div_out.over,
      (div_out.rem[0] < REM_W'(div_out.top)) && (div_out.rem[1] < REM_W'(div_out.top))
      && (div_out.rem[2] < REM_W'(div_out.top)))
   `LBN_ASSERT_IMPLY(a_over_hits_full_scale, clock, reset,
      valid_ff[NUM_STAGES-1] && out_over_ff,
      (out_ff[0] == '1) || (out_ff[1] == '1) || (out_ff[2] == '1))

endmodule
